// ===== design/node_accel_velocity_gather_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the node velocity gather unit
// Shared clocked assertion forms; each module supplies clk and rst.
// ---------------------------------------------------------------------------
`ifndef NODE_ACCEL_VELOCITY_GATHER_UNIT_ASSERT_SVH
`define NODE_ACCEL_VELOCITY_GATHER_UNIT_ASSERT_SVH

// expr must never hold
`define NAVG_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// cond implies conseq in the same cycle
`define NAVG_IMPLY(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// cond implies conseq in the next cycle
`define NAVG_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== design/navg_pkg.sv =====
// ---------------------------------------------------------------------------
// navg_pkg
// Shared widths, constants and the per-node record type.
// ---------------------------------------------------------------------------
package navg_pkg;

  localparam int SUM_W             = 48;
  localparam int Q_W               = 32;
  localparam int NODE_W            = 16;
  localparam int MASS_W            = 31;
  localparam int DT_W              = 32;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam logic [DT_W-1:0] DT_RESET = 32'd4295;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic [SUM_W-1:0]        mass;
    logic [SUM_W-1:0]        wmass;
    logic signed [SUM_W-1:0] fx;
    logic signed [SUM_W-1:0] fy;
    logic signed [SUM_W-1:0] mx;
    logic signed [SUM_W-1:0] my;
    logic                    fixed_x;
    logic                    fixed_y;
  } node_rec_t;

endpackage

// ===== design/navg_div.sv =====
// ---------------------------------------------------------------------------
// navg_div
// Restoring divider, one quotient bit per cycle, sticky quotient overflow.
// ---------------------------------------------------------------------------
module navg_div #(
  parameter int NUM_W = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [navg_pkg::SUM_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [navg_pkg::SUM_W-1:0] quo,
  output logic                      ovf
);
  import navg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_sh;
  logic [SUM_W-1:0] den_r;
  logic [SUM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, num_sh[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? SUM_W'(rem_sh - {1'b0, den_r}) : rem_sh[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
      ovf    <= 1'b0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= rem_next;
      quo    <= {quo[SUM_W-2:0], ge};
      ovf    <= ovf | quo[SUM_W-1];
    end
  end

endmodule

// ===== design/navg_front.sv =====
// ---------------------------------------------------------------------------
// navg_front
// Accepts contributions, keeps the saturating running sums, closes nodes.
// ---------------------------------------------------------------------------
module navg_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [navg_pkg::NODE_W-1:0]        node_id,
  input  logic [navg_pkg::MASS_W-1:0]        elem_mass,
  input  logic signed [navg_pkg::Q_W-1:0]    force_x,
  input  logic signed [navg_pkg::Q_W-1:0]    force_y,
  input  logic [navg_pkg::MASS_W-1:0]        weighted_mass,
  input  logic signed [navg_pkg::Q_W-1:0]    momentum_x,
  input  logic signed [navg_pkg::Q_W-1:0]    momentum_y,
  input  logic                              fixed_x,
  input  logic                              fixed_y,
  input  logic                              last_of_node,
  input  logic                              q_full,
  output logic                              push,
  output navg_pkg::node_rec_t               push_rec
);
  import navg_pkg::*;

  logic [SUM_W-1:0]        mass_sum, wmass_sum;
  logic signed [SUM_W-1:0] fx_sum, fy_sum, mx_sum, my_sum;
  logic                    accept;

  function automatic logic signed [SUM_W-1:0] sadd(input logic signed [SUM_W-1:0] acc,
                                                  input logic signed [Q_W-1:0] v);
    logic signed [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + (SUM_W+1)'(v);
    if (s[SUM_W] != s[SUM_W-1])
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] uadd(input logic [SUM_W-1:0] acc,
                                           input logic [MASS_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign push       = accept && last_of_node;

  always_comb begin
    push_rec.node    = node_id;
    push_rec.mass    = uadd(mass_sum, elem_mass);
    push_rec.wmass   = uadd(wmass_sum, weighted_mass);
    push_rec.fx      = sadd(fx_sum, force_x);
    push_rec.fy      = sadd(fy_sum, force_y);
    push_rec.mx      = sadd(mx_sum, momentum_x);
    push_rec.my      = sadd(my_sum, momentum_y);
    push_rec.fixed_x = fixed_x;
    push_rec.fixed_y = fixed_y;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      mass_sum  <= '0;
      wmass_sum <= '0;
      fx_sum    <= '0;
      fy_sum    <= '0;
      mx_sum    <= '0;
      my_sum    <= '0;
    end else if (accept) begin
      mass_sum  <= push_rec.mass;
      wmass_sum <= push_rec.wmass;
      fx_sum    <= push_rec.fx;
      fy_sum    <= push_rec.fy;
      mx_sum    <= push_rec.mx;
      my_sum    <= push_rec.my;
    end
  end

endmodule

// ===== design/navg_queue.sv =====
// ---------------------------------------------------------------------------
// navg_queue
// Short FIFO of closed node records between front and back.
// ---------------------------------------------------------------------------
module navg_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  navg_pkg::node_rec_t push_rec,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output navg_pkg::node_rec_t head_rec
);
  import navg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  node_rec_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_rec   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_rec;
  end

endmodule

// ===== design/navg_back.sv =====
// ---------------------------------------------------------------------------
// navg_back
// Per-node sequencer: mass third, four quotients, dt products, output reg.
// ---------------------------------------------------------------------------
module navg_back #(
  parameter int FRAC_BITS = navg_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  navg_pkg::node_rec_t             head_rec,
  output logic                            pop,
  input  logic [navg_pkg::DT_W-1:0]        time_step,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [navg_pkg::NODE_W-1:0]      out_node,
  output logic [navg_pkg::MASS_W-1:0]      nodal_mass,
  output logic signed [navg_pkg::Q_W-1:0]  accel_x,
  output logic signed [navg_pkg::Q_W-1:0]  accel_y,
  output logic signed [navg_pkg::Q_W-1:0]  velocity_x,
  output logic signed [navg_pkg::Q_W-1:0]  velocity_y,
  output logic                            divide_error
);
  import navg_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_THIRD = 4'd1;
  localparam logic [3:0] S_AX    = 4'd2;
  localparam logic [3:0] S_AY    = 4'd3;
  localparam logic [3:0] S_VX    = 4'd4;
  localparam logic [3:0] S_VY    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;

  // divide by three, 16 bits a step: floor(y / 3) = (y * RECIP3) >> RECIP_SHIFT
  // holds for every y below 2^19
  localparam int                 DIGIT_W     = 16;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [DIGIT_W+1:0] RECIP3      = 18'h2AAAB;
  localparam logic [1:0]         THIRD_LAST  = 2'd2;

  logic [3:0]         state;
  node_rec_t          rec;
  logic [SUM_W-1:0]   third;
  logic [1:0]         third_cnt, third_rem, third_r;
  logic [DIGIT_W+1:0] third_y;
  logic [RECIP_SHIFT+DIGIT_W-1:0] third_prod;
  logic [DIGIT_W-1:0] third_q;
  logic [Q_W-1:0]     ax, ay, qvx, qvy;
  logic [Q_W-1:0]     px, py;
  logic               err, launched;
  logic               is_div, skip, neg;
  logic [NUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_den;
  logic               div_start, div_busy, div_done, div_ovf;
  logic [SUM_W-1:0]   div_quo;
  logic [Q_W-1:0]     quot_sat;
  logic [Q_W-1:0]     vx_sat, vy_sat;
  logic               load_out;

  function automatic logic [SUM_W-1:0] mag48(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(0) - v : v;
  endfunction

  function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(0) - v : v;
  endfunction

  function automatic logic [Q_W-1:0] sat_quot(input logic [SUM_W-1:0] q,
                                             input logic o, input logic n);
    if (n) begin
      if (o || q > SUM_W'(33'h0_8000_0000)) return {1'b1, {(Q_W-1){1'b0}}};
      return Q_W'(SUM_W'(0) - q);
    end
    if (o || q > SUM_W'(32'h7FFF_FFFF)) return {1'b0, {(Q_W-1){1'b1}}};
    return q[Q_W-1:0];
  endfunction

  // quotient plus or minus product, clamped to 32 bits
  function automatic logic [Q_W-1:0] vel_sum(input logic [Q_W-1:0] q,
                                            input logic [Q_W-1:0] p, input logic n);
    logic signed [Q_W:0] s;
    s = {q[Q_W-1], q} + (n ? (Q_W+1)'(0) - {1'b0, p} : {1'b0, p});
    if (s[Q_W] != s[Q_W-1])
      return s[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    return s[Q_W-1:0];
  endfunction

  // one digit of mass / 3: the mass shifts out of the top of third while
  // the quotient digits shift in at the bottom
  always_comb begin
    third_y    = {third_rem, third[SUM_W-1 -: DIGIT_W]};
    third_prod = (RECIP_SHIFT+DIGIT_W)'(third_y) * (RECIP_SHIFT+DIGIT_W)'(RECIP3);
    third_q    = third_prod[RECIP_SHIFT +: DIGIT_W];
    third_r    = 2'(third_y - {third_q, 1'b0} - {2'b00, third_q});
  end

  always_comb begin
    is_div  = 1'b1;
    skip    = 1'b0;
    neg     = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state)
      S_AX: begin
        div_num = {mag48(rec.fx), {FRAC_BITS{1'b0}}};
        div_den = third;
        skip    = third == '0;
        neg     = rec.fx[SUM_W-1];
      end
      S_AY: begin
        div_num = {mag48(rec.fy), {FRAC_BITS{1'b0}}};
        div_den = third;
        skip    = third == '0;
        neg     = rec.fy[SUM_W-1];
      end
      S_VX: begin
        div_num = {mag48(rec.mx), {FRAC_BITS{1'b0}}};
        div_den = rec.wmass;
        skip    = rec.wmass == '0;
        neg     = rec.mx[SUM_W-1];
      end
      S_VY: begin
        div_num = {mag48(rec.my), {FRAC_BITS{1'b0}}};
        div_den = rec.wmass;
        skip    = rec.wmass == '0;
        neg     = rec.my[SUM_W-1];
      end
      default: is_div = 1'b0;
    endcase
  end

  assign div_start = is_div && !launched && !skip;
  assign quot_sat  = sat_quot(div_quo, div_ovf, neg);
  assign pop       = state == S_IDLE && head_valid;
  assign vx_sat    = vel_sum(qvx, px, ax[Q_W-1]);
  assign vy_sat    = vel_sum(qvy, py, ay[Q_W-1]);
  assign load_out  = state == S_SUM && (!result_valid || !result_stall);

  navg_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launched     <= 1'b0;
      err          <= 1'b0;
      third_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load_out)
        result_valid <= 1'b1;
      else if (!result_stall)
        result_valid <= 1'b0;

      if (pop) begin
        err       <= 1'b0;
        third_cnt <= '0;
        state     <= S_THIRD;
      end else if (state == S_THIRD) begin
        third_cnt <= third_cnt + 1'b1;
        if (third_cnt == THIRD_LAST)
          state <= S_AX;
      end else if (is_div) begin
        if (skip) begin
          err   <= 1'b1;
          state <= state + 1'b1;
        end else if (!launched) begin
          launched <= 1'b1;
        end else if (div_done) begin
          launched <= 1'b0;
          state    <= state + 1'b1;
        end
      end else if (state == S_MUL) begin
        state <= S_SUM;
      end else if (load_out) begin
        state <= S_IDLE;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      rec       <= head_rec;
      third     <= head_rec.mass;
      third_rem <= '0;
    end
    if (state == S_THIRD) begin
      third     <= {third[SUM_W-DIGIT_W-1:0], third_q};
      third_rem <= third_r;
    end
    if (is_div && skip) begin
      unique case (state)
        S_AX:    ax  <= '0;
        S_AY:    ay  <= '0;
        S_VX:    qvx <= '0;
        default: qvy <= '0;
      endcase
    end else if (is_div && launched && div_done) begin
      unique case (state)
        S_AX:    ax    <= quot_sat;
        S_AY:    ay    <= quot_sat;
        S_VX:    qvx   <= quot_sat;
        default: qvy   <= quot_sat;
      endcase
    end
    if (state == S_MUL) begin
      px <= Q_W'(({32'd0, mag32(ax)} * {32'd0, time_step}) >> 32);
      py <= Q_W'(({32'd0, mag32(ay)} * {32'd0, time_step}) >> 32);
    end
    if (load_out) begin
      out_node     <= rec.node;
      nodal_mass   <= (third > SUM_W'(31'h7FFF_FFFF)) ? {MASS_W{1'b1}} : third[MASS_W-1:0];
      accel_x      <= rec.fixed_x ? '0 : ax;
      accel_y      <= rec.fixed_y ? '0 : ay;
      velocity_x   <= rec.fixed_x ? '0 : vx_sat;
      velocity_y   <= rec.fixed_y ? '0 : vy_sat;
      divide_error <= err;
    end
  end

`include "node_accel_velocity_gather_unit_assert.svh"

  `NAVG_NEVER(a_start_while_busy, div_start && div_busy, "divider restarted while busy")
  `NAVG_IMPLY(a_done_unexpected, div_done, launched, "divider result with no request")
  `NAVG_NEXT(a_pop_clears_err, pop, !err, "error flag not cleared on new node")

endmodule

// ===== design/node_accel_velocity_gather_unit.sv =====
// ---------------------------------------------------------------------------
// node_accel_velocity_gather_unit
// Node acceleration and velocity gather. Contributions sorted by node enter
// on the item channel; the front keeps six saturating 48-bit sums and takes
// one request per cycle while the record queue (two nodes deep) has room.
// A request marked last_of_node closes its node: the sums go to the queue
// and restart at zero. The back takes one node at a time: mass/3 by a
// reciprocal multiply on 16-bit digits, then force x and y over that third
// and momentum x and y over the weighted mass through a shared restoring
// divider, one quotient bit per cycle; then the dt products and the
// saturated velocity sum. Quotients are Q16.16 at the default FRAC_BITS;
// a zero divisor skips its divide, gives zero and sets divide_error. The
// front stalls only when two closed nodes are already waiting. Results sit
// in an output register so the back can start the next node while a result
// is stalled. time_step (Q0.32, reset 4295) is written through cfg_write /
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce.
// ---------------------------------------------------------------------------
module node_accel_velocity_gather_unit #(
  parameter int FRAC_BITS = navg_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [navg_pkg::DT_W-1:0]        cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [navg_pkg::NODE_W-1:0]      node_id,
  input  logic [navg_pkg::MASS_W-1:0]      elem_mass,
  input  logic signed [navg_pkg::Q_W-1:0]  force_x,
  input  logic signed [navg_pkg::Q_W-1:0]  force_y,
  input  logic [navg_pkg::MASS_W-1:0]      weighted_mass,
  input  logic signed [navg_pkg::Q_W-1:0]  momentum_x,
  input  logic signed [navg_pkg::Q_W-1:0]  momentum_y,
  input  logic                            fixed_x,
  input  logic                            fixed_y,
  input  logic                            last_of_node,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [navg_pkg::NODE_W-1:0]      out_node,
  output logic [navg_pkg::MASS_W-1:0]      nodal_mass,
  output logic signed [navg_pkg::Q_W-1:0]  accel_x,
  output logic signed [navg_pkg::Q_W-1:0]  accel_y,
  output logic signed [navg_pkg::Q_W-1:0]  velocity_x,
  output logic signed [navg_pkg::Q_W-1:0]  velocity_y,
  output logic                            divide_error
);
  import navg_pkg::*;

  logic [DT_W-1:0] time_step;
  logic            q_full, q_push, q_pop, q_head_valid;
  node_rec_t       push_rec, head_rec;

  // time step register
  always_ff @(posedge clk) begin
    if (rst)
      time_step <= DT_RESET;
    else if (cfg_write)
      time_step <= cfg_data;
  end

  // front: accumulate and close nodes
  navg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .node_id       (node_id),
    .elem_mass     (elem_mass),
    .force_x       (force_x),
    .force_y       (force_y),
    .weighted_mass (weighted_mass),
    .momentum_x    (momentum_x),
    .momentum_y    (momentum_y),
    .fixed_x       (fixed_x),
    .fixed_y       (fixed_y),
    .last_of_node  (last_of_node),
    .q_full        (q_full),
    .push          (q_push),
    .push_rec      (push_rec)
  );

  // decouples accumulation from the long per-node divide sequence
  navg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (push_rec),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_rec   (head_rec)
  );

  // back: divides, dt products, result register
  navg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_rec     (head_rec),
    .pop          (q_pop),
    .time_step    (time_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_node     (out_node),
    .nodal_mass   (nodal_mass),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .divide_error (divide_error)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: node acceleration and velocity gather testbench
// Streams node contributions in sorted segments, predicts each closed node's
// mass, acceleration, velocity and divide flag in a local fixed-point model,
// and checks every result in order under random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  import navg_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam longint Q_MAX = 64'sh7FFFFFFF;
  localparam longint Q_MIN = -64'sh80000000;
  localparam longint S48_MAX = 64'sh7FFFFFFFFFFF;
  localparam longint S48_MIN = -64'sh800000000000;
  localparam logic [63:0] U48_MAX = 64'hFFFFFFFFFFFF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;  // one node through the back, with margin

  // one contribution request
  typedef struct {
    logic [NODE_W-1:0]        node;
    logic [MASS_W-1:0]        emass;
    logic signed [Q_W-1:0]    fx;
    logic signed [Q_W-1:0]    fy;
    logic [MASS_W-1:0]        wmass;
    logic signed [Q_W-1:0]    mx;
    logic signed [Q_W-1:0]    my;
    logic                     fix_x;
    logic                     fix_y;
    logic                     last;
  } contrib_t;

  // one finished node
  typedef struct {
    logic [NODE_W-1:0]  node;
    logic [MASS_W-1:0]  mass;
    logic [Q_W-1:0]     ax;
    logic [Q_W-1:0]     ay;
    logic [Q_W-1:0]     vx;
    logic [Q_W-1:0]     vy;
    logic               err;
  } node_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [DT_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [NODE_W-1:0] node_id = '0;
  logic [MASS_W-1:0] elem_mass = '0;
  logic signed [Q_W-1:0] force_x = '0;
  logic signed [Q_W-1:0] force_y = '0;
  logic [MASS_W-1:0] weighted_mass = '0;
  logic signed [Q_W-1:0] momentum_x = '0;
  logic signed [Q_W-1:0] momentum_y = '0;
  logic fixed_x = 1'b0;
  logic fixed_y = 1'b0;
  logic last_of_node = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [NODE_W-1:0] out_node;
  logic [MASS_W-1:0] nodal_mass;
  logic signed [Q_W-1:0] accel_x;
  logic signed [Q_W-1:0] accel_y;
  logic signed [Q_W-1:0] velocity_x;
  logic signed [Q_W-1:0] velocity_y;
  logic divide_error;

  node_accel_velocity_gather_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .node_id(node_id), .elem_mass(elem_mass),
    .force_x(force_x), .force_y(force_y),
    .weighted_mass(weighted_mass),
    .momentum_x(momentum_x), .momentum_y(momentum_y),
    .fixed_x(fixed_x), .fixed_y(fixed_y), .last_of_node(last_of_node),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_node(out_node), .nodal_mass(nodal_mass),
    .accel_x(accel_x), .accel_y(accel_y),
    .velocity_x(velocity_x), .velocity_y(velocity_y),
    .divide_error(divide_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block state: time step and the six running sums
  logic [DT_W-1:0] dt_now = DT_RESET;
  logic [63:0] mass_acc = '0;
  logic [63:0] wmass_acc = '0;
  longint fx_acc = 0;
  longint fy_acc = 0;
  longint mx_acc = 0;
  longint my_acc = 0;

  node_result_t pending_nodes[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;       // when set, neither side idles
  int stall_left = 0;

  // -- fixed-point helpers -------------------------------------------------
  function automatic logic [63:0] add_u48(logic [63:0] acc, logic [63:0] v);
    logic [63:0] r;
    r = acc + v;
    return (r > U48_MAX) ? U48_MAX : r;
  endfunction

  function automatic longint add_s48(longint acc, longint v);
    longint r;
    r = acc + v;
    if (r > S48_MAX) return S48_MAX;
    if (r < S48_MIN) return S48_MIN;
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // (num << FRAC) / den, truncated toward zero, clamped; zero on zero den
  function automatic longint q_quotient(longint num, logic [63:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    bit neg;
    neg = num < 0;
    if (den == 0) return 0;
    mag = neg ? 128'(-num) : 128'(num);
    q = mag / den;
    if (q > (128'd1 << (32 - FRAC))) return neg ? Q_MIN : Q_MAX;
    q = (mag << FRAC) / den;
    if (neg) return (q > 128'h80000000) ? Q_MIN : -longint'(q[63:0]);
    return (q > 128'h7FFFFFFF) ? Q_MAX : longint'(q[63:0]);
  endfunction

  // accel * dt, dt in Q0.32, truncated toward zero
  function automatic longint scale_dt(longint a);
    logic [127:0] p;
    bit neg;
    neg = a < 0;
    p = (neg ? 128'(-a) : 128'(a)) * dt_now;
    p = p >> 32;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Accumulate one request; on the closing one queue the expected node
  task automatic gather_contrib(contrib_t c);
    logic [63:0] third;
    longint ax, ay, vx, vy;
    node_result_t r;
    mass_acc = add_u48(mass_acc, 64'(c.emass));
    wmass_acc = add_u48(wmass_acc, 64'(c.wmass));
    fx_acc = add_s48(fx_acc, longint'(c.fx));
    fy_acc = add_s48(fy_acc, longint'(c.fy));
    mx_acc = add_s48(mx_acc, longint'(c.mx));
    my_acc = add_s48(my_acc, longint'(c.my));
    if (!c.last) return;
    third = mass_acc / 3;
    ax = q_quotient(fx_acc, third);
    ay = q_quotient(fy_acc, third);
    vx = clamp32(q_quotient(mx_acc, wmass_acc) + scale_dt(ax));
    vy = clamp32(q_quotient(my_acc, wmass_acc) + scale_dt(ay));
    // a fixed axis still flags a zero divisor
    if (c.fix_x) begin
      ax = 0;
      vx = 0;
    end
    if (c.fix_y) begin
      ay = 0;
      vy = 0;
    end
    r.node = c.node;
    r.mass = (third > 64'h7FFFFFFF) ? 31'h7FFFFFFF : third[MASS_W-1:0];
    r.ax = ax[31:0];
    r.ay = ay[31:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.err = (third == 0) || (wmass_acc == 0);
    pending_nodes.push_back(r);
    mass_acc = '0;
    wmass_acc = '0;
    fx_acc = 0;
    fy_acc = 0;
    mx_acc = 0;
    my_acc = 0;
  endtask

  // -- request driver: called at a falling edge, returns at one ------------
  task automatic send_contrib(contrib_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    node_id = c.node;
    elem_mass = c.emass;
    force_x = c.fx;
    force_y = c.fy;
    weighted_mass = c.wmass;
    momentum_x = c.mx;
    momentum_y = c.my;
    fixed_x = c.fix_x;
    fixed_y = c.fix_y;
    last_of_node = c.last;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    gather_contrib(c);
    @(negedge clk);
  endtask

  function automatic contrib_t mk(logic [NODE_W-1:0] node, logic [MASS_W-1:0] em,
                                  logic [Q_W-1:0] fx, logic [Q_W-1:0] fy,
                                  logic [MASS_W-1:0] wm, logic [Q_W-1:0] mx,
                                  logic [Q_W-1:0] my, logic fix_x, logic fix_y,
                                  logic last);
    contrib_t c;
    c.node = node;
    c.emass = em;
    c.fx = fx;
    c.fy = fy;
    c.wmass = wm;
    c.mx = mx;
    c.my = my;
    c.fix_x = fix_x;
    c.fix_y = fix_y;
    c.last = last;
    return c;
  endfunction

  // Q values biased towards the edges and towards sizes that divide sensibly
  function automatic logic [Q_W-1:0] pick_q();
    logic [Q_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = 32'h7FFFFFFF;
      2: v = 32'h80000000;
      3, 4: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h00400000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass();
    logic [MASS_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 31'h7FFFFFFF;
      2: v = MASS_W'($urandom_range(0, 3));
      3, 4: v = 31'($urandom);
      default: v = MASS_W'($urandom_range(32'h00004000, 32'h00400000));
    endcase
    return v;
  endfunction

  // Quiesce, then write the time step
  task automatic write_time_step(logic [DT_W-1:0] dt);
    item_valid = 1'b0;
    wait (pending_nodes.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data = dt;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    dt_now = dt;
  endtask

  // -- result side: stall drawn per result, checked at the rising edge -----
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    node_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
    if (!rst && result_valid && !result_stall) begin
      stall_left <= no_idle ? 0 : $urandom_range(0, 9);
      if (pending_nodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: node %0d", out_node);
      end else begin
        e = pending_nodes.pop_front();
        if (out_node !== e.node || nodal_mass !== e.mass || accel_x !== e.ax ||
            accel_y !== e.ay || velocity_x !== e.vx || velocity_y !== e.vy ||
            divide_error !== e.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch node exp %0d got %0d  mass exp %h got %h",
                     e.node, out_node, e.mass, nodal_mass);
            $display("  accel exp %h %h got %h %h", e.ax, e.ay, accel_x, accel_y);
            $display("  vel exp %h %h got %h %h  err exp %b got %b",
                     e.vx, e.vy, velocity_x, velocity_y, e.err, divide_error);
          end
        end
      end
    end
  end

  // -- tests ---------------------------------------------------------------
  // Single-contribution nodes, first run at the reset time step
  task automatic test_basic_nodes();
    send_contrib(mk(16'd1, 31'h30000, 32'h10000, 32'hFFFF0000, 31'h10000,
                    32'h20000, 32'hFFFE0000, 1'b0, 1'b0, 1'b1));
    send_contrib(mk(16'hFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                    31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1));
    send_contrib(mk(16'h0000, 31'h1, 32'h7FFFFFFF, 32'h80000000, 31'h1,
                    32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b1));
  endtask

  // Zero divisors: no mass, mass below three, no weighted mass (also fixed)
  task automatic test_zero_divisors();
    send_contrib(mk(16'd5, 31'h0, 32'h12345, 32'hFFFEDCBA, 31'h10000,
                    32'h1000, 32'h2000, 1'b0, 1'b0, 1'b1));
    send_contrib(mk(16'd6, 31'h2, 32'h12345, 32'h54321, 31'h0,
                    32'h1000, 32'hFFFFF000, 1'b0, 1'b0, 1'b1));
    send_contrib(mk(16'd7, 31'h60000, 32'h12345, 32'h54321, 31'h0,
                    32'h1000, 32'h2000, 1'b1, 1'b1, 1'b1));
  endtask

  // Each axis held fixed on its own, flags taken from the closing request
  task automatic test_fixed_axes();
    send_contrib(mk(16'd8, 31'h90000, 32'h30000, 32'h30000, 31'h20000,
                    32'h40000, 32'h40000, 1'b1, 1'b0, 1'b1));
    send_contrib(mk(16'd9, 31'h90000, 32'h30000, 32'h30000, 31'h20000,
                    32'h40000, 32'h40000, 1'b1, 1'b1, 1'b0));
    send_contrib(mk(16'd9, 31'h90000, 32'hFFFD0000, 32'h30000, 31'h20000,
                    32'hFFFC0000, 32'h40000, 1'b0, 1'b1, 1'b1));
  endtask

  // Multi-request segments, ids that differ inside a segment
  task automatic test_segments();
    send_contrib(mk(16'd20, 31'h10000, 32'h8000, 32'h7FFFFFFF, 31'h8000,
                    32'h7FFFFFFF, 32'h100, 1'b0, 1'b0, 1'b0));
    send_contrib(mk(16'd20, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b0));
    send_contrib(mk(16'd21, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b1));
    send_contrib(mk(16'hAAAA, 31'h5555, 32'h55555555, 32'hAAAAAAAA, 31'h2AAA,
                    32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b0, 1'b1));
  endtask

  // Random segments of one to six requests; some with scrambled ids
  task automatic test_random_stream(int count);
    contrib_t c;
    int seg_len;
    int sent;
    logic [NODE_W-1:0] base;
    sent = 0;
    while (sent < count) begin
      seg_len = $urandom_range(1, 6);
      base = NODE_W'($urandom);
      no_idle = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < seg_len; i++) begin
        c = mk(($urandom_range(0, 9) == 0) ? NODE_W'($urandom) : base,
               pick_mass(), pick_q(), pick_q(), pick_mass(), pick_q(), pick_q(),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
               i == seg_len - 1);
        send_contrib(c);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_nodes();
    test_zero_divisors();
    test_fixed_axes();
    test_segments();

    write_time_step(32'd0);
    test_basic_nodes();
    test_random_stream(300);
    write_time_step(32'hFFFFFFFF);
    test_basic_nodes();
    test_random_stream(300);
    write_time_step($urandom);
    test_random_stream(300);
    write_time_step(32'h80000000);
    test_random_stream(350);

    item_valid = 1'b0;
    wait (pending_nodes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
